FILE: hdl/cwb_pkg.sv
// shared constants, register codes and controller/datapath interface types
`timescale 1ns / 1ps

package cwb_pkg;

  localparam int MAX_HALF_WINDOW  = 32;
  localparam int SAMPLE_FRAC_BITS = 16;

  localparam int SAMPLE_W = SAMPLE_FRAC_BITS + 1;
  localparam int TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int HALF_W   = 6;

  localparam logic [SAMPLE_W-1:0] ONE_Q = SAMPLE_W'(1) << SAMPLE_FRAC_BITS;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  // delay line storage: circular buffer, only the newest 2h+1 entries are read
  localparam int DL_DEPTH = 2 * MAX_HALF_WINDOW + 2;
  localparam int DL_AW    = $clog2(DL_DEPTH);
  localparam int RAM_DEPTH = 1 << DL_AW;

  localparam int SEEN_W = 16;
  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  localparam longint SUM_MAX = longint'(2 * MAX_HALF_WINDOW + 1) *
                               ((longint'(1) << SAMPLE_W) - 1);
  localparam int SUM_W     = $clog2(SUM_MAX + 1);
  localparam int NUM_W     = SUM_W + 1;
  localparam int DEN_W     = $clog2(4 * MAX_HALF_WINDOW + 1);
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = HALF_W;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_MODE    = 1'b1;

  localparam logic MODE_BOXCAR    = 1'b0;
  localparam logic MODE_TRAPEZOID = 1'b1;

  typedef struct packed {
    logic             load_in;
    logic             load_pad;
    logic             rd_en;
    logic [DL_AW-1:0] rd_idx;
    logic             sum_load_s;
    logic             sum_add;
    logic             sum_run;
    logic             f2h_load;
    logic             div_start;
    logic             commit;
    logic             out_load;
    logic             out_last;
    logic             end_series;
  } cwb_cmd_t;

  typedef struct packed {
    logic [HALF_W-1:0] h;
    logic              sum_fresh;
    logic              due;
    logic              div_done;
    logic              out_free;
  } cwb_sts_t;

endpackage

FILE: hdl/cwb_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module cwb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/cwb_datapath.sv
// datapath: config regs, delay line ram, window sum, serial divider, output register
`timescale 1ns / 1ps

module cwb_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cwb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cwb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [cwb_pkg::SAMPLE_W-1:0]        in_sample,
  input  cwb_pkg::cwb_cmd_t                   cmd,
  output cwb_pkg::cwb_sts_t                   sts,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cwb_pkg::SAMPLE_W-1:0]        out_flux,
  output logic                                m_tlast
);
  import cwb_pkg::*;

  logic [HALF_W-1:0]   half_window;
  logic                bin_mode;
  logic [HALF_W-1:0]   h_eff;
  logic [DL_AW-1:0]    wp;
  logic [SEEN_W-1:0]   seen;
  logic                sum_ok;
  logic [HALF_W-1:0]   sum_h;
  logic [SAMPLE_W-1:0] s_cur;
  logic [SUM_W-1:0]    wsum;
  logic [SAMPLE_W-1:0] f2h;
  logic                rd_valid;
  logic [SAMPLE_W-1:0] ram_q;
  logic [SAMPLE_W-1:0] rd_data;
  logic [DL_AW-1:0]    raddr;

  logic                 div_busy;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [NUM_W-1:0]     div_q;
  logic [DEN_W-1:0]     div_rem;
  logic [DEN_W-1:0]     div_den;
  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     den;
  logic [DEN_W:0]       trial;
  logic                 trial_ge;
  logic [SAMPLE_W-1:0]  q_sat;

  // out-of-range half window is clamped
  always_comb begin
    if (half_window == '0) begin
      h_eff = HALF_W'(1);
    end else if (half_window > HALF_W'(MAX_HALF_WINDOW)) begin
      h_eff = HALF_W'(MAX_HALF_WINDOW);
    end else begin
      h_eff = half_window;
    end
  end

  // pre-push index j sits j+1 slots behind the write pointer
  assign raddr   = wp - DL_AW'(1) - cmd.rd_idx;
  assign rd_data = rd_valid ? ram_q : ONE_Q;

  cwb_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wp),
    .wdata (s_cur),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // numerator and divisor of the rounded average
  always_comb begin
    if (bin_mode == MODE_TRAPEZOID) begin
      num = {wsum, 1'b0} - NUM_W'(s_cur) - NUM_W'(f2h) + NUM_W'({h_eff, 1'b0});
      den = DEN_W'({h_eff, 2'b00});
    end else begin
      num = NUM_W'(wsum) + NUM_W'(h_eff);
      den = DEN_W'({h_eff, 1'b1});
    end
  end

  assign trial    = {div_rem, div_q[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, div_den};
  assign q_sat    = (div_q[NUM_W-1:SAMPLE_W] != '0) ? SAMPLE_MAX : div_q[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window <= HALF_W'(1);
      bin_mode    <= MODE_BOXCAR;
      wp          <= '0;
      seen        <= '0;
      sum_ok      <= 1'b0;
      div_busy    <= 1'b0;
      div_cnt     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HALF_WINDOW: half_window <= cfg_data;
          REG_BIN_MODE:    bin_mode    <= cfg_data[0];
          default:         ;
        endcase
      end
      if (cmd.commit) begin
        wp <= wp + DL_AW'(1);
      end
      if (cmd.end_series) begin
        seen   <= '0;
        sum_ok <= 1'b0;
      end else if (cmd.commit) begin
        if (seen != SEEN_MAX) begin
          seen <= seen + SEEN_W'(1);
        end
        sum_ok <= 1'b1;
      end
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= DIV_CNT_W'(NUM_W);
      end else if (div_busy) begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(1)) begin
          div_busy <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      s_cur <= in_sample;
    end else if (cmd.load_pad) begin
      s_cur <= ONE_Q;
    end
    if (cmd.rd_en) begin
      rd_valid <= SEEN_W'(cmd.rd_idx) < seen;
    end
    if (cmd.sum_load_s) begin
      wsum <= SUM_W'(s_cur);
    end else if (cmd.sum_add) begin
      wsum <= wsum + SUM_W'(rd_data);
    end else if (cmd.sum_run) begin
      wsum <= wsum + SUM_W'(s_cur) - SUM_W'(rd_data);
    end
    if (cmd.f2h_load) begin
      f2h <= rd_data;
    end
    if (cmd.commit) begin
      sum_h <= h_eff;
    end
    // restoring division, one quotient bit per cycle
    if (cmd.div_start) begin
      div_q   <= num;
      div_rem <= '0;
      div_den <= den;
    end else if (div_busy) begin
      div_q   <= {div_q[NUM_W-2:0], trial_ge};
      div_rem <= trial_ge ? DEN_W'(trial - {1'b0, div_den}) : trial[DEN_W-1:0];
    end
    if (cmd.out_load) begin
      out_flux <= q_sat;
      m_tlast  <= cmd.out_last;
    end
  end

  assign sts.h         = h_eff;
  assign sts.sum_fresh = sum_ok && (sum_h == h_eff);
  assign sts.due       = seen >= SEEN_W'(h_eff);
  assign sts.div_done  = !div_busy;
  assign sts.out_free  = !m_tvalid;

endmodule

FILE: hdl/cwb_ctrl.sv
// controller: sequences reads, sum update, divide and result hand-off per push
`timescale 1ns / 1ps

module cwb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tlast,
  input  cwb_pkg::cwb_sts_t sts,
  output cwb_pkg::cwb_cmd_t cmd
);
  import cwb_pkg::*;

  typedef enum logic [2:0] {
    IDLE, PUSH, RUN_OLD, RUN_F2H, SWEEP, START_DIV, WAIT_DIV
  } state_t;

  state_t            state, state_next;
  logic [DL_AW-1:0]  j, j_next;
  logic [HALF_W-1:0] rem, rem_next;
  logic              flushing, flushing_next;
  logic              last_q, last_q_next;
  logic [DL_AW-1:0]  idx_2h;
  logic [DL_AW-1:0]  idx_2h_m1;

  assign idx_2h    = DL_AW'({sts.h, 1'b0});
  assign idx_2h_m1 = idx_2h - DL_AW'(1);
  assign s_tready  = (state == IDLE);

  always_comb begin
    state_next    = state;
    j_next        = j;
    rem_next      = rem;
    flushing_next = flushing;
    last_q_next   = last_q;
    cmd           = '0;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load_in   = 1'b1;
          last_q_next   = s_tlast;
          flushing_next = 1'b0;
          state_next    = PUSH;
        end
      end
      PUSH: begin
        cmd.rd_en = 1'b1;
        if (sts.sum_fresh) begin
          cmd.rd_idx = idx_2h;
          state_next = RUN_OLD;
        end else begin
          // window length changed or new series: rebuild the sum
          cmd.sum_load_s = 1'b1;
          cmd.rd_idx     = '0;
          j_next         = '0;
          state_next     = SWEEP;
        end
      end
      RUN_OLD: begin
        cmd.sum_run = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_idx  = idx_2h_m1;
        state_next  = RUN_F2H;
      end
      RUN_F2H: begin
        cmd.f2h_load = 1'b1;
        state_next   = START_DIV;
      end
      SWEEP: begin
        cmd.sum_add = 1'b1;
        if (j == idx_2h_m1) begin
          cmd.f2h_load = 1'b1;
          state_next   = START_DIV;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = j + DL_AW'(1);
          j_next     = j + DL_AW'(1);
        end
      end
      START_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = WAIT_DIV;
      end
      WAIT_DIV: begin
        if (sts.div_done && (!sts.due || sts.out_free)) begin
          cmd.commit   = 1'b1;
          cmd.out_load = sts.due;
          cmd.out_last = flushing && (rem == '0);
          if (flushing) begin
            if (rem == '0) begin
              cmd.end_series = 1'b1;
              state_next     = IDLE;
            end else begin
              rem_next     = rem - HALF_W'(1);
              cmd.load_pad = 1'b1;
              state_next   = PUSH;
            end
          end else if (last_q) begin
            flushing_next = 1'b1;
            rem_next      = sts.h - HALF_W'(1);
            cmd.load_pad  = 1'b1;
            state_next    = PUSH;
          end else begin
            state_next = IDLE;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      j        <= '0;
      rem      <= '0;
      flushing <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state    <= state_next;
      j        <= j_next;
      rem      <= rem_next;
      flushing <= flushing_next;
      last_q   <= last_q_next;
    end
  end

  // a result is only handed over into an empty output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending result");

  // the divider is busy right after a start
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider did not start");

  // the final flush push always yields the last result and returns to idle
  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && flushing && rem == '0) |-> (cmd.out_load && cmd.out_last) ##1
    (state == IDLE))
    else $error("flush ended without last result");

endmodule

FILE: hdl/centered_window_binning_unit.sv
// top level of the centered window binning unit
`timescale 1ns / 1ps

// Centered window binning of an unsigned Q1.16 relative-flux stream. Every
// input item pushes one sample into a 128-entry circular delay line; once
// half_window (h) samples of a series have arrived, each push yields one
// result: the boxcar average (S + h) / (2h+1) over the 2h+1 newest samples,
// or in trapezoid mode (2S - newest - oldest + 2h) / (4h), rounded to nearest
// and saturated to 17 bits. Samples outside the series count as 1.0. An item
// with tlast set also pushes h padding samples of 1.0, so the whole series
// drains, and the final result carries tlast; the line is then logically
// cleared through the fill count (no clearing pass). Each push consists of
// two delay line reads, the divider start, the bit-serial divider and the
// commit; a new item is taken only in the idle state, once the pushes of the
// previous item are all committed. The first push of a series, and
// the first one after a half_window change, rebuilds the window sum by
// reading 2h entries of the ram. A push that has a result also waits
// while the previous result still sits in the output register. An item
// without tlast costs one push, an item with tlast 1 + h pushes. A new item
// is accepted while a result is still waiting in the output register.
// half_window is clamped to 1..32; configuration is to be written by the
// user between items only, the block itself does not enforce this.
module centered_window_binning_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [cwb_pkg::CFG_IDX_W-1:0]      cfg_index,   // 0 half_window, 1 bin_mode
  input  logic [cwb_pkg::CFG_DATA_W-1:0]     cfg_data,
  // sample items
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [cwb_pkg::TDATA_W-1:0]        s_tdata,     // [16:0] flux_sample
  input  logic                               s_tlast,     // last_sample
  // binned items
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [cwb_pkg::TDATA_W-1:0]        m_tdata,     // [16:0] binned_flux
  output logic                               m_tlast      // last_bin
);
  import cwb_pkg::*;

  cwb_cmd_t            cmd;
  cwb_sts_t            sts;
  logic [SAMPLE_W-1:0] out_flux;

  // sequencing of one push at a time
  cwb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, arithmetic and result register
  cwb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (s_tdata[SAMPLE_W-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_flux  (out_flux),
    .m_tlast   (m_tlast)
  );

  // pad the result to whole bytes
  assign m_tdata = TDATA_W'(out_flux);

endmodule

FILE: bench/tb_centered_window_binning_unit.sv
// self-checking testbench for the centered window binning unit
`timescale 1ns / 1ps

typedef struct packed {
  logic [cwb_pkg::SAMPLE_W-1:0] flux;
  logic                         last;
} flux_bin_t;

// tracks the delay line and registers of the block, queues the binned items
// each sample item should produce and checks what comes out
class binning_scoreboard;
  logic [cwb_pkg::SAMPLE_W-1:0] taps [cwb_pkg::DL_DEPTH];
  int unsigned                  fill;
  logic [cwb_pkg::HALF_W-1:0]   half_window;
  logic                         bin_mode;
  flux_bin_t                    due_bins [$];
  int unsigned samples_in   = 0;
  int unsigned series_in    = 0;
  int unsigned bins_checked = 0;
  int unsigned reg_writes   = 0;
  int unsigned failures     = 0;

  function new();
    flush_line();
    half_window = {{(cwb_pkg::HALF_W-1){1'b0}}, 1'b1};
    bin_mode    = cwb_pkg::MODE_BOXCAR;
  endfunction

  // line back to all 1.0, series count to zero
  function void flush_line();
    foreach (taps[k]) taps[k] = cwb_pkg::ONE_Q;
    fill = 0;
  endfunction

  function void write_reg(logic [cwb_pkg::CFG_IDX_W-1:0] idx,
                          logic [cwb_pkg::CFG_DATA_W-1:0] val);
    reg_writes++;
    if (idx == cwb_pkg::REG_HALF_WINDOW) half_window = val;
    else if (idx == cwb_pkg::REG_BIN_MODE) bin_mode = val[0];
  endfunction

  // half window as the block uses it: zero acts as one, clamp at the max
  function int unsigned span();
    if (half_window == 0) return 1;
    if (half_window > cwb_pkg::MAX_HALF_WINDOW) return cwb_pkg::MAX_HALF_WINDOW;
    return half_window;
  endfunction

  // push one sample, form the window average, return whether it is due
  function bit window_average(logic [cwb_pkg::SAMPLE_W-1:0] s,
                              output logic [cwb_pkg::SAMPLE_W-1:0] avg);
    int unsigned     h;
    int              k;
    longint unsigned box, trap, q, v;
    bit              due;
    h = span();
    for (k = cwb_pkg::DL_DEPTH - 1; k > 0; k--) taps[k] = taps[k-1];
    taps[0] = s;
    due = (fill >= h);
    if (fill < cwb_pkg::SEEN_MAX) fill++;
    box  = 0;
    trap = 0;
    for (k = 0; k <= 2 * h; k++) begin
      v = taps[k];
      box += v;
      trap += (k == 0 || k == 2 * h) ? v : 2 * v;
    end
    if (bin_mode == cwb_pkg::MODE_TRAPEZOID) q = (trap + 2 * h) / (4 * h);
    else q = (box + h) / (2 * h + 1);
    if (q > cwb_pkg::SAMPLE_MAX) q = cwb_pkg::SAMPLE_MAX;
    avg = q[cwb_pkg::SAMPLE_W-1:0];
    return due;
  endfunction

  // an accepted sample item: queue every binned item it causes
  function void note_sample(logic [cwb_pkg::SAMPLE_W-1:0] s, logic last);
    flux_bin_t                    batch [$];
    flux_bin_t                    b;
    logic [cwb_pkg::SAMPLE_W-1:0] avg;
    int unsigned                  h, k;
    samples_in++;
    h = span();
    b.last = 1'b0;
    if (window_average(s, avg)) begin
      b.flux = avg;
      batch.push_back(b);
    end
    if (last) begin
      // flush: pad with 1.0 until the whole series has drained
      for (k = 0; k < h; k++) begin
        if (window_average(cwb_pkg::ONE_Q, avg)) begin
          b.flux = avg;
          batch.push_back(b);
        end
      end
      flush_line();
      series_in++;
    end
    foreach (batch[i]) begin
      b = batch[i];
      b.last = last && (i == batch.size() - 1);
      due_bins.push_back(b);
    end
  endfunction

  function void check_bin(logic [cwb_pkg::SAMPLE_W-1:0] flux, logic last);
    flux_bin_t want;
    if (due_bins.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected binned item: flux %0d last %0b", flux, last);
      return;
    end
    want = due_bins.pop_front();
    bins_checked++;
    if (flux !== want.flux || last !== want.last) begin
      failures++;
      if (failures <= 10)
        $display("binned item %0d: expected flux %0d last %0b, got flux %0d last %0b",
                 bins_checked, want.flux, want.last, flux, last);
    end
  endfunction
endclass

module tb_centered_window_binning_unit;
  import cwb_pkg::*;

  // idle time before a register write: covers a full-window rebuild plus
  // the divider, for an item that leaves no result behind
  localparam int DRAIN_CYCLES = 4 * MAX_HALF_WINDOW + 64;
  localparam logic [SAMPLE_W-1:0] FLUX_MAX = SAMPLE_MAX;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata = '0;    // [16:0] flux_sample
  logic                  s_tlast = 1'b0;  // last_sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;         // [16:0] binned_flux
  logic                  m_tlast;         // last_bin

  int send_idle  = 0;  // percent of cycles the sender holds back
  int recv_stall = 0;  // percent of cycles the receiver stalls

  binning_scoreboard sb = new();

  centered_window_binning_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random back-pressure, changed on the falling edge
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_stall);
  end

  // every binned item taken at a rising edge goes to the checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_bin(m_tdata[SAMPLE_W-1:0], m_tlast);
  end

  // one sample item; tvalid stays high into the next item unless idling
  task automatic send(input logic [SAMPLE_W-1:0] flux, input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = TDATA_W'(flux);
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(flux, last);
    @(negedge clk);
  endtask

  // wait until every expected binned item is out and the block has gone quiet
  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.due_bins.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // both registers; the unused upper bits of a mode write are random
  task automatic set_config(input logic [CFG_DATA_W-1:0] half, input logic mode);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word    = CFG_DATA_W'($urandom);
    mode_word[0] = mode;
    write_reg(REG_HALF_WINDOW, half);
    write_reg(REG_BIN_MODE, mode_word);
  endtask

  // near the 1.0 baseline or full-range noise in equal shares, plus the rails
  function automatic logic [SAMPLE_W-1:0] rand_flux();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return '0;
      1: return FLUX_MAX;
      2: return ONE_Q;
      3, 4, 5: return SAMPLE_W'(ONE_Q - 4096 + $urandom_range(8191));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // small windows dominate so flushes stay short; zero and oversize included
  function automatic logic [CFG_DATA_W-1:0] rand_half();
    int unsigned r;
    r = $urandom_range(19);
    case (r)
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'(MAX_HALF_WINDOW);
      3: return CFG_DATA_W'($urandom_range(63, MAX_HALF_WINDOW + 1));
      4, 5, 6: return CFG_DATA_W'($urandom_range(31, 5));
      default: return CFG_DATA_W'($urandom_range(4, 1));
    endcase
  endfunction

  initial begin
    int          phase;
    int unsigned sent, len, k;
    bit          broken;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: rails with the smallest window
    set_config(CFG_DATA_W'(1), MODE_BOXCAR);
    send(FLUX_MAX, 1'b0);
    send('0, 1'b0);
    send(FLUX_MAX, 1'b0);
    send('0, 1'b1);
    // half window zero behaves as one, trapezoid
    settle();
    set_config('0, MODE_TRAPEZOID);
    send(FLUX_MAX, 1'b0);
    send(FLUX_MAX, 1'b1);
    // oversize half window clamps; series shorter than the window
    settle();
    set_config(CFG_DATA_W'(63), MODE_BOXCAR);
    send('0, 1'b0);
    send(FLUX_MAX, 1'b0);
    send('0, 1'b1);
    settle();
    set_config(CFG_DATA_W'(MAX_HALF_WINDOW + 1), MODE_TRAPEZOID);
    send(SAMPLE_W'(FLUX_MAX - 1), 1'b1);
    // widest window at full scale, flushed with 1.0 padding
    settle();
    set_config(CFG_DATA_W'(MAX_HALF_WINDOW), MODE_BOXCAR);
    send(FLUX_MAX, 1'b0);
    send(FLUX_MAX, 1'b0);
    send(FLUX_MAX, 1'b1);
    // registers changed in the middle of a series
    settle();
    set_config(CFG_DATA_W'(2), MODE_BOXCAR);
    send('0, 1'b0);
    send('0, 1'b0);
    settle();
    set_config(CFG_DATA_W'(4), MODE_TRAPEZOID);
    send(FLUX_MAX, 1'b0);
    send(SAMPLE_W'(1), 1'b0);
    send(ONE_Q, 1'b0);
    send(SAMPLE_W'(99999), 1'b1);

    // random series under four handshake profiles
    for (phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle = 0;  recv_stall = 0;
          set_config(CFG_DATA_W'(1), MODE_BOXCAR);
        end
        1: begin
          send_idle = 83; recv_stall = 0;
          set_config(CFG_DATA_W'(MAX_HALF_WINDOW), MODE_TRAPEZOID);
        end
        2: begin
          send_idle = 0;  recv_stall = 83;
          set_config('0, MODE_TRAPEZOID);
        end
        default: begin
          send_idle = 28; recv_stall = 28;
          set_config(CFG_DATA_W'(63), MODE_BOXCAR);
        end
      endcase
      sent = 0;
      while (sent < 24) begin
        if ($urandom_range(2) == 0) begin
          settle();
          set_config(rand_half(), 1'($urandom_range(1)));
        end
        len = $urandom_range(12, 1);
        // now and then a series runs on without its last item
        broken = ($urandom_range(99) < 15);
        for (k = 0; k < len; k++) send(rand_flux(), !broken && k == len - 1);
        sent += len;
      end
    end
    send(rand_flux(), 1'b1);
    settle();

    $display("covered %0d sample items in %0d series, %0d binned items checked",
             sb.samples_in, sb.series_in, sb.bins_checked);
    $display("%0d register writes: half windows 0..63, boxcar and trapezoid, %0d failures",
             sb.reg_writes, sb.failures);
    if (sb.failures == 0 && sb.due_bins.size() == 0) begin
      $display("centered_window_binning_unit verification clean");
    end else begin
      $display("centered_window_binning_unit verification failed");
    end
    $finish;
  end

  // hang guard: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("centered_window_binning_unit verification failed");
    $finish;
  end

endmodule
